// ===== hdl/bmf_pkg.sv =====
// Package for the 2-D box mean filter: sizes, widths, state codes, command/status structs.
// Used by bmf_ctrl, bmf_datapath and box_mean_filter_2d_core.
`timescale 1ns / 1ps
`default_nettype none
package bmf_pkg;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_RADIUS = 9;
    localparam int PIXEL_BITS = 16;
    localparam int MAX_HEIGHT = 1024;
    localparam int RING_DEPTH = 2 * MAX_RADIUS + 1;
    localparam int SPAN_MAX   = 2 * MAX_RADIUS;
    localparam int LINE_DEPTH = SPAN_MAX * MAX_WIDTH;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
    localparam int LINE_ABITS = $clog2(LINE_DEPTH);
    localparam int SLOT_BITS  = $clog2(SPAN_MAX);
    localparam int RING_BITS  = $clog2(RING_DEPTH);
    localparam int CSUM_BITS  = PIXEL_BITS + $clog2(RING_DEPTH);
    localparam int WSUM_BITS  = CSUM_BITS + $clog2(RING_DEPTH);
    localparam int AREA_BITS  = 2 * $clog2(RING_DEPTH + 1);
    localparam int QUOT_BITS  = WSUM_BITS;
    localparam int DIV_CNT_BITS = $clog2(QUOT_BITS + 1);

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_ACCUM = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    typedef struct packed {
        logic load;     // capture pixel
        logic accum;    // update sums and stores
        logic div_start;
        logic div_step;
        logic restart;
    } t_cmd;

    typedef struct packed {
        logic emit;     // this pixel produces a result
        logic div_done;
    } t_status;
endpackage
`default_nettype wire

// ===== hdl/bmf_ctrl.sv =====
// Controller for the box mean filter: sequences read, accumulate, divide, output.
// Depends on bmf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bmf_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic            i_cfg_we,
    input  wire logic            i_out_stall,
    input  wire bmf_pkg::t_status i_status,
    output logic                 o_stall,
    output logic                 o_valid,
    output bmf_pkg::t_cmd        o_cmd
);
    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bmf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.restart = i_cfg_we;
        o_stall = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            bmf_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = bmf_pkg::ST_READ;
                end
            end
            bmf_pkg::ST_READ: n_state = bmf_pkg::ST_ACCUM;
            bmf_pkg::ST_ACCUM: begin
                o_cmd.accum = 1'b1;
                if (i_status.emit) begin
                    n_state = bmf_pkg::ST_DIV;
                end else begin
                    n_state = bmf_pkg::ST_IDLE;
                end
            end
            bmf_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = bmf_pkg::ST_OUT;
                end
            end
            bmf_pkg::ST_OUT: begin
                o_valid = 1'b1;
                if (!i_out_stall) begin
                    n_state = bmf_pkg::ST_IDLE;
                end
            end
            default: n_state = bmf_pkg::ST_IDLE;
        endcase
        o_cmd.div_start = (r_state == bmf_pkg::ST_ACCUM) && i_status.emit;
    end
endmodule
`default_nettype wire

// ===== hdl/bmf_datapath.sv =====
// Datapath for the box mean filter: config, position counters, line store, column sums,
// horizontal ring, window sum and a restoring divider. Depends on bmf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bmf_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [1:0]                    i_cfg_index,
    input  wire logic [10:0]                   i_cfg_data,
    input  wire logic [15:0]                   i_pixel_value,
    input  wire bmf_pkg::t_cmd                 i_cmd,
    output bmf_pkg::t_status                   o_status,
    output logic [15:0]                        o_mean_value,
    output logic [9:0]                         o_out_column,
    output logic [9:0]                         o_out_row,
    output logic                               o_frame_done
);
    localparam int CB = bmf_pkg::COL_BITS;
    localparam int RB = bmf_pkg::ROW_BITS;
    localparam int CS = bmf_pkg::CSUM_BITS;
    localparam int WS = bmf_pkg::WSUM_BITS;
    localparam int QB = bmf_pkg::QUOT_BITS;
    localparam int AB = bmf_pkg::AREA_BITS;

    logic [10:0] r_width, r_height;
    logic [3:0]  r_radius;
    logic [CB-1:0] r_col;
    logic [RB-1:0] r_row;
    logic [WS-1:0] r_wsum;
    logic [bmf_pkg::PIXEL_BITS-1:0] r_pix;
    logic [CS-1:0] r_csum_rd, r_ring_rd;
    logic [15:0]   r_line_rd;
    logic [bmf_pkg::SLOT_BITS-1:0] r_slot;   // row mod span
    logic [bmf_pkg::RING_BITS-1:0] r_rslot;  // col mod ring

    logic [15:0]   line_mem [bmf_pkg::LINE_DEPTH];
    logic [CS-1:0] csum_mem [bmf_pkg::MAX_WIDTH];
    logic [CS-1:0] ring_mem [bmf_pkg::RING_DEPTH];

    // effective register values
    logic [CB:0] eff_w;
    logic [RB:0] eff_h;
    logic [3:0]  eff_r;
    logic [4:0]  span;
    logic [4:0]  ring;
    always_comb begin
        eff_w = (r_width == 11'd0) ? (CB+1)'(1) :
                (r_width > 11'(bmf_pkg::MAX_WIDTH)) ? (CB+1)'(bmf_pkg::MAX_WIDTH)
                                                    : (CB+1)'(r_width);
        eff_h = (r_height == 11'd0) ? (RB+1)'(1) :
                (r_height > 11'(bmf_pkg::MAX_HEIGHT)) ? (RB+1)'(bmf_pkg::MAX_HEIGHT)
                                                      : (RB+1)'(r_height);
        eff_r = (r_radius > 4'(bmf_pkg::MAX_RADIUS)) ? 4'(bmf_pkg::MAX_RADIUS) : r_radius;
        span  = {eff_r, 1'b0};
        ring  = span + 5'd1;
    end

    logic [bmf_pkg::LINE_ABITS-1:0] line_addr;
    assign line_addr = bmf_pkg::LINE_ABITS'(r_slot) * bmf_pkg::LINE_ABITS'(bmf_pkg::MAX_WIDTH)
                     + bmf_pkg::LINE_ABITS'(r_col);

    logic col_last, row_last, emit;
    assign col_last = ({1'b0, r_col} + (CB+1)'(1)) >= eff_w;
    assign row_last = ({1'b0, r_row} + (RB+1)'(1)) >= eff_h;
    assign emit = (RB'(span) <= r_row) && (CB'(span) <= r_col);

    logic [CS-1:0] full;
    logic [WS-1:0] wsum_next;
    always_comb begin
        full = ((r_row == '0) ? CS'(0) : r_csum_rd) + CS'(r_pix);
        wsum_next = ((r_col == '0) ? WS'(0) : r_wsum) + WS'(full);
        if ({1'b0, r_col} >= (CB+1)'(ring)) begin
            wsum_next = wsum_next - WS'(r_ring_rd);
        end
    end

    // memory reads, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pix <= i_pixel_value;
        end
        r_line_rd <= line_mem[line_addr];
        r_csum_rd <= csum_mem[r_col];
        r_ring_rd <= ring_mem[r_rslot];
    end

    logic [CS-1:0] oldest;
    assign oldest = (RB'(span) <= r_row) ? CS'(r_line_rd) : CS'(0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accum) begin
            csum_mem[r_col] <= (span == 5'd0) ? CS'(0) : full - oldest;
            ring_mem[r_rslot] <= full;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.accum && span != 5'd0) begin
            line_mem[line_addr] <= r_pix;
        end
    end

    // config and position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 11'd1024;
            r_height <= 11'd1024;
            r_radius <= 4'd9;
            r_col    <= '0;
            r_row    <= '0;
            r_slot   <= '0;
            r_rslot  <= '0;
            r_wsum   <= '0;
        end else if (i_cmd.restart) begin
            case (i_cfg_index)
                bmf_pkg::REG_WIDTH:  r_width  <= i_cfg_data;
                bmf_pkg::REG_HEIGHT: r_height <= i_cfg_data;
                bmf_pkg::REG_RADIUS: r_radius <= i_cfg_data[3:0];
                default: ;
            endcase
            if (i_cfg_index <= bmf_pkg::REG_RADIUS) begin
                r_col   <= '0;
                r_row   <= '0;
                r_slot  <= '0;
                r_rslot <= '0;
                r_wsum  <= '0;
            end
        end else if (i_cmd.accum) begin
            r_wsum <= wsum_next;
            if (col_last) begin
                r_col   <= '0;
                r_rslot <= '0;
                if (row_last) begin
                    r_row  <= '0;
                    r_slot <= '0;
                end else begin
                    r_row  <= r_row + RB'(1);
                    r_slot <= ({1'b0, r_slot} + 6'd1 >= {1'b0, span}) ? '0
                            : r_slot + bmf_pkg::SLOT_BITS'(1);
                end
            end else begin
                r_col   <= r_col + CB'(1);
                r_rslot <= ({1'b0, r_rslot} + 6'd1 >= {1'b0, ring}) ? '0
                         : r_rslot + bmf_pkg::RING_BITS'(1);
            end
        end
    end

    // result tags captured with the sum
    logic [AB-1:0] area;
    assign area = AB'(ring) * AB'(ring);
    always_ff @(posedge i_clk) begin
        if (i_cmd.accum) begin
            o_out_column <= 10'(r_col - CB'(eff_r));
            o_out_row    <= 10'(r_row - RB'(eff_r));
            o_frame_done <= col_last && row_last;
        end
    end

    // restoring divider: one quotient bit per cycle
    logic [QB-1:0] r_quot;
    logic [AB:0]   r_rem;
    logic [AB-1:0] r_div;
    logic [bmf_pkg::DIV_CNT_BITS-1:0] r_cnt;
    logic [AB:0] rem_sh;
    assign rem_sh = {r_rem[AB-1:0], r_quot[QB-1]};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_quot <= wsum_next;
            r_rem  <= '0;
            r_div  <= area;
            r_cnt  <= bmf_pkg::DIV_CNT_BITS'(QB);
        end else if (i_cmd.div_step && r_cnt != '0) begin
            r_cnt <= r_cnt - bmf_pkg::DIV_CNT_BITS'(1);
            if (rem_sh >= {1'b0, r_div}) begin
                r_rem  <= rem_sh - {1'b0, r_div};
                r_quot <= {r_quot[QB-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_quot <= {r_quot[QB-2:0], 1'b0};
            end
        end
    end

    assign o_mean_value = r_quot[15:0];
    assign o_status.emit = emit;
    assign o_status.div_done = (r_cnt == '0);
endmodule
`default_nettype wire

// ===== hdl/box_mean_filter_2d_core.sv =====
// Top level of the 2-D box mean filter: joins bmf_ctrl and bmf_datapath.
// Depends on bmf_pkg, bmf_ctrl, bmf_datapath.
//
//  channel | signals                                                 | direction
//  pixel   | i_valid, o_stall, i_pixel_value                         | in
//  result  | o_valid, i_stall, o_mean_value, o_out_*, o_frame_done   | out
//  config  | i_cfg_we, i_cfg_index, i_cfg_data                       | in
//
// Each pixel passes through transfer, store read and accumulate; a pixel with a result
// then goes through the shift-subtract divider and an output state.
// Synchronous active-low reset; stores hold no reset and are written before read.
// A stalled result holds the block; the next pixel transfers after the result leaves.
`timescale 1ns / 1ps
`default_nettype none
module box_mean_filter_2d_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [10:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [15:0] i_pixel_value,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_mean_value,
    output logic [9:0]       o_out_column,
    output logic [9:0]       o_out_row,
    output logic             o_frame_done
);
    bmf_pkg::t_cmd    cmd;
    bmf_pkg::t_status status;

    bmf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_cfg_we(i_cfg_we),
        .i_out_stall(i_stall), .i_status(status), .o_stall(o_stall),
        .o_valid(o_valid), .o_cmd(cmd)
    );

    bmf_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_pixel_value(i_pixel_value), .i_cmd(cmd), .o_status(status),
        .o_mean_value(o_mean_value), .o_out_column(o_out_column),
        .o_out_row(o_out_row), .o_frame_done(o_frame_done)
    );
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench for box_mean_filter_2d_core: directed and random frame streams checked against an in-bench
// sliding-window mean predictor held in a small scoreboard class. Depends on bmf_pkg.
`timescale 1ns / 1ps

class mean_scoreboard;
    int unsigned width_cfg = 1024;
    int unsigned height_cfg = 1024;
    int unsigned radius_cfg = 9;
    int unsigned col_pos;
    int unsigned row_pos;
    // full frame copy; windows are summed directly from it
    logic [15:0] frame_pix [0:1023][0:1023];
    logic [15:0] exp_mean [$];
    logic [9:0]  exp_col [$];
    logic [9:0]  exp_row [$];
    logic        exp_done [$];
    int unsigned errors;
    int unsigned checked;

    function void write_reg(logic [1:0] idx, logic [10:0] data);
        if (idx == bmf_pkg::REG_WIDTH) width_cfg = data;
        else if (idx == bmf_pkg::REG_HEIGHT) height_cfg = data;
        else if (idx == bmf_pkg::REG_RADIUS) radius_cfg = data[3:0];
        else return;
        col_pos = 0;
        row_pos = 0;
    endfunction

    function void note_pixel(logic [15:0] pix);
        int unsigned w, h, r, span, area;
        longint unsigned acc;
        w = (width_cfg < 1) ? 1 : (width_cfg > 1024 ? 1024 : width_cfg);
        h = (height_cfg < 1) ? 1 : (height_cfg > 1024 ? 1024 : height_cfg);
        r = (radius_cfg > 9) ? 9 : radius_cfg;
        span = 2 * r;
        frame_pix[row_pos][col_pos] = pix;
        if (row_pos >= span && col_pos >= span) begin
            acc = 0;
            for (int y = row_pos - span; y <= row_pos; y++)
                for (int x = col_pos - span; x <= col_pos; x++)
                    acc += frame_pix[y][x];
            area = (span + 1) * (span + 1);
            exp_mean.push_back(16'(acc / area));
            exp_col.push_back(10'(col_pos - r));
            exp_row.push_back(10'(row_pos - r));
            exp_done.push_back(row_pos + 1 >= h && col_pos + 1 >= w);
        end
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endfunction

    function void check_result(logic [15:0] mean, logic [9:0] col, logic [9:0] row,
                               logic done);
        if (exp_mean.size() == 0) begin
            $error("result with none pending: mean %0d col %0d row %0d", mean, col, row);
            errors++;
            return;
        end
        checked++;
        if (mean !== exp_mean[0]) begin
            $error("mean_value expected %0d actual %0d", exp_mean[0], mean); errors++;
        end
        if (col !== exp_col[0]) begin
            $error("out_column expected %0d actual %0d", exp_col[0], col); errors++;
        end
        if (row !== exp_row[0]) begin
            $error("out_row expected %0d actual %0d", exp_row[0], row); errors++;
        end
        if (done !== exp_done[0]) begin
            $error("frame_done expected %0d actual %0d", exp_done[0], done); errors++;
        end
        void'(exp_mean.pop_front());
        void'(exp_col.pop_front());
        void'(exp_row.pop_front());
        void'(exp_done.pop_front());
    endfunction

    function int unsigned pending();
        return exp_mean.size();
    endfunction
endclass

module tb_top;
    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;
    logic        pix_valid;
    logic        pix_stall;
    logic [15:0] pix_value;
    logic        res_valid;
    logic        res_stall;
    logic [15:0] res_mean;
    logic [9:0]  res_col;
    logic [9:0]  res_row;
    logic        res_done;

    mean_scoreboard sb;
    bit quiet_tail;
    int unsigned pix_sent;
    int unsigned frames_run;

    box_mean_filter_2d_core u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(pix_valid), .o_stall(pix_stall), .i_pixel_value(pix_value),
        .o_valid(res_valid), .i_stall(res_stall), .o_mean_value(res_mean),
        .o_out_column(res_col), .o_out_row(res_row), .o_frame_done(res_done)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    // result side: random stall bursts, check on each transfer
    initial begin
        res_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
                sb.check_result(res_mean, res_col, res_row, res_done);
            @(negedge clk);
            if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) begin
                    @(posedge clk);
                    @(negedge clk);
                end
            end
            res_stall <= 1'b0;
        end
    end

    task automatic send_pixel(logic [15:0] pix);
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        pix_valid <= 1'b1;
        pix_value <= pix;
        do @(posedge clk); while (pix_stall);
        sb.note_pixel(pix);
        pix_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        pix_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        // border pixels may still be in flight with no result
        repeat (40) @(negedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [10:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_frame(int unsigned w, int unsigned h, int unsigned r);
        drain();
        write_cfg(bmf_pkg::REG_WIDTH, 11'(w));
        write_cfg(bmf_pkg::REG_HEIGHT, 11'(h));
        write_cfg(bmf_pkg::REG_RADIUS, 11'(r));
    endtask

    // random frame content, mostly uniform random with extremes mixed in
    function automatic logic [15:0] pick_pixel();
        case ($urandom_range(0, 5))
            0: return 16'hFFFF;
            1: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_frames(int unsigned n);
        int unsigned w, h;
        w = (sb.width_cfg < 1) ? 1 : (sb.width_cfg > 1024 ? 1024 : sb.width_cfg);
        h = (sb.height_cfg < 1) ? 1 : (sb.height_cfg > 1024 ? 1024 : sb.height_cfg);
        repeat (n) begin
            for (int p = 0; p < w * h; p++) send_pixel(pick_pixel());
            frames_run++;
        end
    endtask

    initial begin
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = bmf_pkg::REG_WIDTH;
        cfg_data = '0;
        pix_valid = 1'b0;
        pix_value = '0;
        quiet_tail = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: r = 0 passes every pixel, with full-scale and zero values
        set_frame(4, 2, 0);
        send_pixel(16'hFFFF); send_pixel(16'h0000); send_pixel(16'h0001);
        send_pixel(16'h8000); send_pixel(16'h7FFF); send_pixel(16'hAAAA);
        send_pixel(16'h5555); send_pixel(16'hFFFF);
        // all-max 3x3 window, then width 1 (no interior), then zero-size registers
        set_frame(3, 3, 1);
        repeat (9) send_pixel(16'hFFFF);
        set_frame(1, 3, 1);
        repeat (3) send_pixel(16'h1234);
        set_frame(0, 0, 0);
        send_pixel(16'h4321);
        // window larger than frame: no results
        set_frame(3, 5, 2);
        repeat (15) send_pixel(16'hFFFF);
        // radius above the cap acts as the cap; widest row saturates
        set_frame(19, 19, 15);
        run_frames(1);
        set_frame(2047, 1, 0);
        run_frames(1);

        // random phases
        while (pix_sent < 1450) begin
            set_frame($urandom_range(1, 16), $urandom_range(1, 8), $urandom_range(0, 3));
            run_frames($urandom_range(1, 2));
            if ($urandom_range(0, 3) == 0) drain();
        end
        set_frame(12, 4, 1);
        quiet_tail = 1'b1;
        run_frames(2);
        drain();

        $display("covered %0d pixels over %0d frames, %0d results checked",
                 pix_sent, frames_run, sb.checked);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
